/* design/fbrf_pkg.sv */
package fbrf_pkg;

    // command codes carried on the input channel
    typedef enum logic [1:0] {
        CMD_WRITE = 2'd0,
        CMD_READ  = 2'd1,
        CMD_RECT  = 2'd2,
        CMD_COPY  = 2'd3
    } cmd_t;

    // default frame store geometry
    localparam int MAX_COLS_DEF = 128;
    localparam int MAX_ROWS_DEF = 128;

    // signed width for geometry arithmetic: 16-bit coordinates plus band overhang
    localparam int GW = 18;

    // configuration register indexes
    localparam int CFG_IDX_W = 8;
    localparam logic [CFG_IDX_W-1:0] CFG_FRAME_COLS = 8'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_FRAME_ROWS = 8'd1;
    localparam logic [7:0] FRAME_SIZE_RESET = 8'd128;

    localparam logic [7:0] ALPHA_FULL = 8'hFF;

    // painting passes of a rectangle, in order
    localparam int BOX_IDX_W = 3;
    localparam logic [BOX_IDX_W-1:0] BOX_FILL   = 3'd0;
    localparam logic [BOX_IDX_W-1:0] BOX_TOP    = 3'd1;
    localparam logic [BOX_IDX_W-1:0] BOX_BOTTOM = 3'd2;
    localparam logic [BOX_IDX_W-1:0] BOX_LEFT   = 3'd3;
    localparam logic [BOX_IDX_W-1:0] BOX_RIGHT  = 3'd4;

    // commands from the controller to the datapath
    typedef struct packed {
        logic                 load;
        logic                 pix_wr;
        logic                 pix_rd;
        logic                 box_setup;
        logic                 copy_setup;
        logic                 box_step;
        logic                 copy_rd;
        logic                 copy_step;
        logic                 res_load;
        logic [BOX_IDX_W-1:0] box_idx;
    } ctl_t;

    // status from the datapath to the controller
    typedef struct packed {
        cmd_t cmd;
        logic box_empty;
        logic copy_fail;
        logic last;
    } sts_t;

endpackage

/* design/framebuffer_rect_fill_and_blit_unit.sv */
// Raster engine over an RGBA frame store (alpha 31:24, red, green, blue 7:0).
// Input channel s_*: one command per transaction (write pixel, read pixel,
// draw rectangle, copy region). Result channel m_*: exactly one transaction
// per command, pixel_value for reads (else zero) and status (1 = copy
// rejected). Configuration channel cfg_*: index 0 frame_cols, 1 frame_rows,
// always ready; write only while no command is in flight.
// One command is worked on at a time; s_ready is high only when idle.
// Rectangle: five painting passes (fill, top, bottom, left, right), each
// with a setup step and then one clipped pixel painted per cycle.
// Copy: a frame store read and then a write for each destination pixel.
// The frame store has a single write port.
// Reset clears the control state and sets both frame sizes to 128; the frame
// store contents are undefined until written.
// A stalled receiver holds the result in the output register; the engine
// waits for it to drain before finishing the next command.
module framebuffer_rect_fill_and_blit_unit #(
    parameter int MAX_COLS = fbrf_pkg::MAX_COLS_DEF,
    parameter int MAX_ROWS = fbrf_pkg::MAX_ROWS_DEF
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic [fbrf_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [7:0]                     cfg_data,
    input  logic                           s_valid,
    output logic                           s_ready,
    input  logic [1:0]                     s_cmd,
    input  logic signed [15:0]             s_a_col,
    input  logic signed [15:0]             s_a_row,
    input  logic signed [15:0]             s_b_col,
    input  logic signed [15:0]             s_b_row,
    input  logic signed [15:0]             s_dest_col,
    input  logic signed [15:0]             s_dest_row,
    input  logic [7:0]                     s_band_width,
    input  logic                           s_fill_enable,
    input  logic [31:0]                    s_border_rgba,
    input  logic [23:0]                    s_fill_rgb,
    output logic                           m_valid,
    input  logic                           m_ready,
    output logic [31:0]                    m_pixel_value,
    output logic                           m_status
);

    fbrf_pkg::ctl_t ctl;
    fbrf_pkg::sts_t sts;

    assign cfg_ready = 1'b1;

    fbrf_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .sts     (sts),
        .ctl     (ctl)
    );

    fbrf_datapath #(
        .MAX_COLS (MAX_COLS),
        .MAX_ROWS (MAX_ROWS)
    ) u_datapath (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg_valid     (cfg_valid),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .s_cmd         (s_cmd),
        .s_a_col       (s_a_col),
        .s_a_row       (s_a_row),
        .s_b_col       (s_b_col),
        .s_b_row       (s_b_row),
        .s_dest_col    (s_dest_col),
        .s_dest_row    (s_dest_row),
        .s_band_width  (s_band_width),
        .s_fill_enable (s_fill_enable),
        .s_border_rgba (s_border_rgba),
        .s_fill_rgb    (s_fill_rgb),
        .ctl           (ctl),
        .sts           (sts),
        .m_pixel_value (m_pixel_value),
        .m_status      (m_status)
    );

endmodule

/* design/fbrf_datapath.sv */
module fbrf_datapath #(
    parameter int MAX_COLS = fbrf_pkg::MAX_COLS_DEF,
    parameter int MAX_ROWS = fbrf_pkg::MAX_ROWS_DEF
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           cfg_valid,
    input  logic [fbrf_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [7:0]                     cfg_data,
    input  logic [1:0]                     s_cmd,
    input  logic signed [15:0]             s_a_col,
    input  logic signed [15:0]             s_a_row,
    input  logic signed [15:0]             s_b_col,
    input  logic signed [15:0]             s_b_row,
    input  logic signed [15:0]             s_dest_col,
    input  logic signed [15:0]             s_dest_row,
    input  logic [7:0]                     s_band_width,
    input  logic                           s_fill_enable,
    input  logic [31:0]                    s_border_rgba,
    input  logic [23:0]                    s_fill_rgb,
    input  fbrf_pkg::ctl_t                 ctl,
    output fbrf_pkg::sts_t                 sts,
    output logic [31:0]                    m_pixel_value,
    output logic                           m_status
);

    localparam int CW    = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
    localparam int RW    = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
    localparam int AW    = CW + RW;
    localparam int DEPTH = 1 << AW;
    localparam int GW    = fbrf_pkg::GW;

    // configuration registers
    logic [7:0] frame_cols_reg;
    logic [7:0] frame_rows_reg;

    // latched command
    fbrf_pkg::cmd_t    cmd_reg;
    logic signed [15:0] a_col_reg, a_row_reg;
    logic signed [15:0] lo_c_reg, hi_c_reg, lo_r_reg, hi_r_reg;
    logic signed [15:0] dest_col_reg, dest_row_reg;
    logic [6:0]         half_reg;
    logic               fill_reg;
    logic [31:0]        border_reg;
    logic [23:0]        fill_rgb_reg;
    logic               status_reg;

    // scan registers
    logic [CW-1:0] wbc_reg, rbc_reg, xmax_reg, x_reg;
    logic [RW-1:0] wbr_reg, rbr_reg, ymax_reg, y_reg;
    logic          rev_x_reg, rev_y_reg;
    logic [31:0]   color_reg;

    // frame store
    logic [31:0] mem [DEPTH];
    logic [31:0] rdata_reg;

    // result registers
    logic [31:0] pix_out_reg;
    logic        status_out_reg;

    // geometry in signed form
    logic signed [GW-1:0] w_s, h_s, hv_s;
    logic signed [GW-1:0] ac_s, ar_s, lc_s, hc_s, lr_s, hr_s, dc_s, dr_s;
    logic                 pix_in;

    always_comb begin
        w_s  = (frame_cols_reg > MAX_COLS) ? GW'(MAX_COLS) : GW'(frame_cols_reg);
        h_s  = (frame_rows_reg > MAX_ROWS) ? GW'(MAX_ROWS) : GW'(frame_rows_reg);
        hv_s = GW'(half_reg);
        ac_s = GW'(a_col_reg);
        ar_s = GW'(a_row_reg);
        lc_s = GW'(lo_c_reg);
        hc_s = GW'(hi_c_reg);
        lr_s = GW'(lo_r_reg);
        hr_s = GW'(hi_r_reg);
        dc_s = GW'(dest_col_reg);
        dr_s = GW'(dest_row_reg);
        pix_in = (ac_s >= 0) && (ac_s < w_s) && (ar_s >= 0) && (ar_s < h_s);
    end

    // box bounds for the current painting pass, clipped to the frame
    logic signed [GW-1:0] bc0, br0, bc1, br1, cc0, cr0, cc1, cr1;
    logic                 box_empty;

    always_comb begin
        case (ctl.box_idx)
            fbrf_pkg::BOX_FILL: begin
                bc0 = lc_s;        br0 = lr_s;        bc1 = hc_s;        br1 = hr_s;
            end
            fbrf_pkg::BOX_TOP: begin
                bc0 = lc_s - hv_s; br0 = lr_s - hv_s; bc1 = hc_s + hv_s; br1 = lr_s + hv_s;
            end
            fbrf_pkg::BOX_BOTTOM: begin
                bc0 = lc_s - hv_s; br0 = hr_s - hv_s; bc1 = hc_s + hv_s; br1 = hr_s + hv_s;
            end
            fbrf_pkg::BOX_LEFT: begin
                bc0 = lc_s - hv_s; br0 = lr_s;        bc1 = lc_s + hv_s; br1 = hr_s;
            end
            default: begin
                bc0 = hc_s - hv_s; br0 = lr_s;        bc1 = hc_s + hv_s; br1 = hr_s;
            end
        endcase
        cc0 = (bc0 < 0) ? '0 : bc0;
        cr0 = (br0 < 0) ? '0 : br0;
        cc1 = (bc1 > w_s - GW'(1)) ? w_s - GW'(1) : bc1;
        cr1 = (br1 > h_s - GW'(1)) ? h_s - GW'(1) : br1;
        box_empty = (cc0 > cc1) || (cr0 > cr1) ||
                    ((ctl.box_idx == fbrf_pkg::BOX_FILL) && !fill_reg);
    end

    // copy checks and clipped extent
    logic signed [GW-1:0] cw_s, ch_s, nx_s, ny_s, room_x, room_y;
    logic                 copy_fail;

    always_comb begin
        cw_s   = hc_s - lc_s;
        ch_s   = hr_s - lr_s;
        room_x = w_s - dc_s;
        room_y = h_s - dr_s;
        nx_s   = (cw_s < room_x) ? cw_s : room_x;
        ny_s   = (ch_s < room_y) ? ch_s : room_y;
        copy_fail = (cw_s <= 0) || (ch_s <= 0) || (lc_s < 0) || (lr_s < 0) ||
                    (hc_s > w_s) || (hr_s > h_s) || (dc_s < 0) || (dr_s < 0) ||
                    (dc_s >= w_s) || (dr_s >= h_s);
    end

    // scan position
    logic          last_x, last_y;
    logic [CW-1:0] wc, rc;
    logic [RW-1:0] wr, rr;

    always_comb begin
        last_x = rev_x_reg ? (x_reg == '0) : (x_reg == xmax_reg);
        last_y = rev_y_reg ? (y_reg == '0) : (y_reg == ymax_reg);
        wc = wbc_reg + x_reg;
        wr = wbr_reg + y_reg;
        rc = rbc_reg + x_reg;
        rr = rbr_reg + y_reg;
    end

    assign sts.cmd       = cmd_reg;
    assign sts.box_empty = box_empty;
    assign sts.copy_fail = copy_fail;
    assign sts.last      = last_x && last_y;

    // configuration writes
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            frame_cols_reg <= fbrf_pkg::FRAME_SIZE_RESET;
            frame_rows_reg <= fbrf_pkg::FRAME_SIZE_RESET;
        end else if (cfg_valid) begin
            if (cfg_index == fbrf_pkg::CFG_FRAME_COLS) frame_cols_reg <= cfg_data;
            if (cfg_index == fbrf_pkg::CFG_FRAME_ROWS) frame_rows_reg <= cfg_data;
        end
    end

    // command capture, corners ordered on the way in
    always_ff @(posedge aclk) begin
        if (ctl.load) begin
            cmd_reg      <= fbrf_pkg::cmd_t'(s_cmd);
            a_col_reg    <= s_a_col;
            a_row_reg    <= s_a_row;
            lo_c_reg     <= (s_b_col < s_a_col) ? s_b_col : s_a_col;
            hi_c_reg     <= (s_b_col < s_a_col) ? s_a_col : s_b_col;
            lo_r_reg     <= (s_b_row < s_a_row) ? s_b_row : s_a_row;
            hi_r_reg     <= (s_b_row < s_a_row) ? s_a_row : s_b_row;
            dest_col_reg <= s_dest_col;
            dest_row_reg <= s_dest_row;
            half_reg     <= s_band_width[7:1];
            fill_reg     <= s_fill_enable;
            border_reg   <= s_border_rgba;
            fill_rgb_reg <= s_fill_rgb;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            status_reg <= 1'b0;
        end else if (ctl.load) begin
            status_reg <= 1'b0;
        end else if (ctl.copy_setup) begin
            status_reg <= copy_fail;
        end
    end

    // scan setup and stepping
    always_ff @(posedge aclk) begin
        if (ctl.box_setup) begin
            wbc_reg   <= cc0[CW-1:0];
            wbr_reg   <= cr0[RW-1:0];
            rbc_reg   <= cc0[CW-1:0];
            rbr_reg   <= cr0[RW-1:0];
            xmax_reg  <= CW'(cc1 - cc0);
            ymax_reg  <= RW'(cr1 - cr0);
            x_reg     <= '0;
            y_reg     <= '0;
            rev_x_reg <= 1'b0;
            rev_y_reg <= 1'b0;
            color_reg <= (ctl.box_idx == fbrf_pkg::BOX_FILL) ?
                         {fbrf_pkg::ALPHA_FULL, fill_rgb_reg} :
                         {fbrf_pkg::ALPHA_FULL, border_reg[23:0]};
        end else if (ctl.copy_setup) begin
            wbc_reg   <= dc_s[CW-1:0];
            wbr_reg   <= dr_s[RW-1:0];
            rbc_reg   <= lc_s[CW-1:0];
            rbr_reg   <= lr_s[RW-1:0];
            xmax_reg  <= CW'(nx_s - 1);
            ymax_reg  <= RW'(ny_s - 1);
            // scan away from the overlap so no source is overwritten before it is read
            rev_x_reg <= dc_s > lc_s;
            rev_y_reg <= dr_s > lr_s;
            x_reg     <= (dc_s > lc_s) ? CW'(nx_s - 1) : '0;
            y_reg     <= (dr_s > lr_s) ? RW'(ny_s - 1) : '0;
        end else if (ctl.box_step || ctl.copy_step) begin
            if (last_x) begin
                x_reg <= rev_x_reg ? xmax_reg : '0;
                y_reg <= rev_y_reg ? y_reg - 1'b1 : y_reg + 1'b1;
            end else begin
                x_reg <= rev_x_reg ? x_reg - 1'b1 : x_reg + 1'b1;
            end
        end
    end

    // frame store ports
    logic          we, re;
    logic [AW-1:0] waddr, raddr;
    logic [31:0]   wdata;

    always_comb begin
        we    = (ctl.pix_wr && pix_in) || ctl.box_step || ctl.copy_step;
        re    = ctl.pix_rd || ctl.copy_rd;
        waddr = ctl.pix_wr ? {a_row_reg[RW-1:0], a_col_reg[CW-1:0]} : {wr, wc};
        raddr = ctl.pix_rd ? {a_row_reg[RW-1:0], a_col_reg[CW-1:0]} : {rr, rc};
        wdata = ctl.pix_wr ? border_reg : (ctl.copy_step ? rdata_reg : color_reg);
    end

    always_ff @(posedge aclk) begin
        if (we) mem[waddr] <= wdata;
        if (re) rdata_reg <= mem[raddr];
    end

    // result register
    always_ff @(posedge aclk) begin
        if (ctl.res_load) begin
            pix_out_reg    <= ((cmd_reg == fbrf_pkg::CMD_READ) && pix_in) ? rdata_reg : '0;
            status_out_reg <= status_reg;
        end
    end

    assign m_pixel_value = pix_out_reg;
    assign m_status      = status_out_reg;

endmodule

/* design/fbrf_ctrl.sv */
module fbrf_ctrl (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           s_valid,
    output logic           s_ready,
    output logic           m_valid,
    input  logic           m_ready,
    input  fbrf_pkg::sts_t sts,
    output fbrf_pkg::ctl_t ctl
);

    typedef enum logic [6:0] {
        S_IDLE = 7'b0000001,
        S_PREP = 7'b0000010,
        S_BOX  = 7'b0000100,
        S_RUN  = 7'b0001000,
        S_CRD  = 7'b0010000,
        S_CWR  = 7'b0100000,
        S_DONE = 7'b1000000
    } state_t;

    state_t                         state_reg, state_next;
    logic [fbrf_pkg::BOX_IDX_W-1:0] box_idx_reg, box_idx_next;
    logic                           m_valid_reg, m_valid_next;

    // sequencing of one command
    always_comb begin
        state_next   = state_reg;
        box_idx_next = box_idx_reg;
        ctl          = '0;
        ctl.box_idx  = box_idx_reg;
        unique case (state_reg)
            S_IDLE: begin
                ctl.load = s_valid;
                if (s_valid) state_next = S_PREP;
            end
            S_PREP: begin
                unique case (sts.cmd)
                    fbrf_pkg::CMD_WRITE: begin
                        ctl.pix_wr = 1'b1;
                        state_next = S_DONE;
                    end
                    fbrf_pkg::CMD_READ: begin
                        ctl.pix_rd = 1'b1;
                        state_next = S_DONE;
                    end
                    fbrf_pkg::CMD_RECT: begin
                        box_idx_next = fbrf_pkg::BOX_FILL;
                        state_next   = S_BOX;
                    end
                    default: begin
                        ctl.copy_setup = 1'b1;
                        state_next     = sts.copy_fail ? S_DONE : S_CRD;
                    end
                endcase
            end
            S_BOX: begin
                ctl.box_setup = 1'b1;
                if (!sts.box_empty) begin
                    state_next = S_RUN;
                end else if (box_idx_reg == fbrf_pkg::BOX_RIGHT) begin
                    state_next = S_DONE;
                end else begin
                    box_idx_next = box_idx_reg + 1'b1;
                end
            end
            S_RUN: begin
                ctl.box_step = 1'b1;
                if (sts.last) begin
                    if (box_idx_reg == fbrf_pkg::BOX_RIGHT) begin
                        state_next = S_DONE;
                    end else begin
                        box_idx_next = box_idx_reg + 1'b1;
                        state_next   = S_BOX;
                    end
                end
            end
            S_CRD: begin
                ctl.copy_rd = 1'b1;
                state_next  = S_CWR;
            end
            S_CWR: begin
                ctl.copy_step = 1'b1;
                state_next    = sts.last ? S_DONE : S_CRD;
            end
            S_DONE: begin
                if (!m_valid_reg || m_ready) begin
                    ctl.res_load = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    // output valid flag
    always_comb begin
        if (ctl.res_load) m_valid_next = 1'b1;
        else if (m_ready) m_valid_next = 1'b0;
        else m_valid_next = m_valid_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            box_idx_reg <= fbrf_pkg::BOX_FILL;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            box_idx_reg <= box_idx_next;
            m_valid_reg <= m_valid_next;
        end
    end

    assign s_ready = (state_reg == S_IDLE);
    assign m_valid = m_valid_reg;

    a_accept_prep: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> (state_reg == S_PREP))
        else $error("accepted transaction did not start");

    a_copy_pair: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_CRD) |=> (state_reg == S_CWR))
        else $error("copy read not followed by write");

    a_box_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (box_idx_reg <= fbrf_pkg::BOX_RIGHT))
        else $error("painting pass index out of range");

    a_result_held: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && !m_ready && state_reg != S_DONE) |=> m_valid_reg)
        else $error("result dropped while stalled");

endmodule

/* tb/fbrf_checker.sv */
`timescale 1ns / 100ps

module fbrf_checker #(
    parameter int MAX_COLS = fbrf_pkg::MAX_COLS_DEF,
    parameter int MAX_ROWS = fbrf_pkg::MAX_ROWS_DEF
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           cfg_valid,
    input  logic                           cfg_ready,
    input  logic [fbrf_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [7:0]                     cfg_data,
    input  logic                           s_valid,
    input  logic                           s_ready,
    input  logic [1:0]                     s_cmd,
    input  logic signed [15:0]             s_a_col,
    input  logic signed [15:0]             s_a_row,
    input  logic signed [15:0]             s_b_col,
    input  logic signed [15:0]             s_b_row,
    input  logic signed [15:0]             s_dest_col,
    input  logic signed [15:0]             s_dest_row,
    input  logic [7:0]                     s_band_width,
    input  logic                           s_fill_enable,
    input  logic [31:0]                    s_border_rgba,
    input  logic [23:0]                    s_fill_rgb,
    input  logic                           m_valid,
    input  logic                           m_ready,
    input  logic [31:0]                    m_pixel_value,
    input  logic                           m_status,
    output int                             mismatches,
    output int                             pending
);

    typedef struct packed {
        logic [31:0] pixel;
        logic        status;
    } outcome_t;

    logic [31:0] frame_mem [MAX_COLS*MAX_ROWS];
    logic [31:0] frame_snap [MAX_COLS*MAX_ROWS];
    logic [7:0]  cols_reg;
    logic [7:0]  rows_reg;
    outcome_t    outcome_q [$];

    function automatic int width_in_use();
        return (int'(cols_reg) > MAX_COLS) ? MAX_COLS : int'(cols_reg);
    endfunction

    function automatic int height_in_use();
        return (int'(rows_reg) > MAX_ROWS) ? MAX_ROWS : int'(rows_reg);
    endfunction

    // paint an inclusive box clipped to the frame
    task automatic paint_box(input int c0, input int r0, input int c1, input int r1,
                             input logic [31:0] v);
        int w;
        int h;
        w = width_in_use();
        h = height_in_use();
        if (c0 < 0) c0 = 0;
        if (r0 < 0) r0 = 0;
        if (c1 > w - 1) c1 = w - 1;
        if (r1 > h - 1) r1 = h - 1;
        for (int r = r0; r <= r1; r++)
            for (int c = c0; c <= c1; c++)
                frame_mem[r*MAX_COLS + c] = v;
    endtask

    // block copy from a snapshot, destination clipped
    function automatic logic blit_model(input int l, input int t, input int rt,
                                        input int b, input int dl, input int dt);
        int w;
        int h;
        int s;
        w = width_in_use();
        h = height_in_use();
        if (rt < l) begin
            s = l; l = rt; rt = s;
        end
        if (b < t) begin
            s = t; t = b; b = s;
        end
        if (rt - l <= 0 || b - t <= 0) return 1'b1;
        if (l < 0 || t < 0 || rt > w || b > h) return 1'b1;
        if (dl < 0 || dt < 0 || dl >= w || dt >= h) return 1'b1;
        frame_snap = frame_mem;
        for (int y = 0; y < b - t && dt + y < h; y++)
            for (int x = 0; x < rt - l && dl + x < w; x++)
                frame_mem[(dt+y)*MAX_COLS + dl + x] = frame_snap[(t+y)*MAX_COLS + l + x];
        return 1'b0;
    endfunction

    // work out the result of one command and update the frame copy
    task automatic run_command(output outcome_t res);
        int ac, ar, bc, br, x0, x1, y0, y1, half, s, w, h;
        logic [31:0] border;
        ac = int'(s_a_col);
        ar = int'(s_a_row);
        bc = int'(s_b_col);
        br = int'(s_b_row);
        w = width_in_use();
        h = height_in_use();
        half = int'(s_band_width >> 1);
        res = '0;
        case (fbrf_pkg::cmd_t'(s_cmd))
            fbrf_pkg::CMD_WRITE: begin
                if (ac >= 0 && ac < w && ar >= 0 && ar < h)
                    frame_mem[ar*MAX_COLS + ac] = s_border_rgba;
            end
            fbrf_pkg::CMD_READ: begin
                if (ac >= 0 && ac < w && ar >= 0 && ar < h)
                    res.pixel = frame_mem[ar*MAX_COLS + ac];
            end
            fbrf_pkg::CMD_RECT: begin
                x0 = ac; x1 = bc; y0 = ar; y1 = br;
                if (x0 >= x1) begin
                    s = x0; x0 = x1; x1 = s;
                end
                if (y0 >= y1) begin
                    s = y0; y0 = y1; y1 = s;
                end
                border = {fbrf_pkg::ALPHA_FULL, s_border_rgba[23:0]};
                if (s_fill_enable)
                    paint_box(x0, y0, x1, y1, {fbrf_pkg::ALPHA_FULL, s_fill_rgb});
                paint_box(x0 - half, y0 - half, x1 + half, y0 + half, border);
                paint_box(x0 - half, y1 - half, x1 + half, y1 + half, border);
                paint_box(x0 - half, y0, x0 + half, y1, border);
                paint_box(x1 - half, y0, x1 + half, y1, border);
            end
            default: begin
                res.status = blit_model(ac, ar, bc, br, int'(s_dest_col), int'(s_dest_row));
            end
        endcase
    endtask

    // watch the three channels
    always @(posedge aclk) begin
        outcome_t got;
        outcome_t want;
        if (!aresetn) begin
            cols_reg <= fbrf_pkg::FRAME_SIZE_RESET;
            rows_reg <= fbrf_pkg::FRAME_SIZE_RESET;
            outcome_q.delete();
            mismatches <= 0;
            pending <= 0;
        end else begin
            if (m_valid && m_ready) begin
                got = '{m_pixel_value, m_status};
                if (outcome_q.size() == 0) begin
                    if (mismatches < 10)
                        $display("unexpected result transaction: pixel %h status %b",
                                 got.pixel, got.status);
                    mismatches <= mismatches + 1;
                end else begin
                    want = outcome_q.pop_front();
                    if (got !== want) begin
                        if (mismatches < 10)
                            $display("result mismatch: pixel %h/%h status %b/%b (exp/act)",
                                     want.pixel, got.pixel, want.status, got.status);
                        mismatches <= mismatches + 1;
                    end
                end
            end
            if (cfg_valid && cfg_ready) begin
                if (cfg_index == fbrf_pkg::CFG_FRAME_COLS) cols_reg <= cfg_data;
                else if (cfg_index == fbrf_pkg::CFG_FRAME_ROWS) rows_reg <= cfg_data;
            end
            if (s_valid && s_ready) begin
                run_command(want);
                outcome_q.push_back(want);
            end
            pending <= outcome_q.size();
        end
    end

endmodule

/* tb/testbench.sv */
`timescale 1ns / 100ps

module testbench;

    localparam int  RUN_LIMIT  = 50000000;
    localparam logic [fbrf_pkg::CFG_IDX_W-1:0] CFG_UNMAPPED = 8'd7;
    localparam int  HOLD_LEN   = 300;

    typedef struct {
        fbrf_pkg::cmd_t     cmd;
        logic signed [15:0] ac, ar, bc, br, dc, dr;
        logic [7:0]         bw;
        logic               fe;
        logic [31:0]        brgba;
        logic [23:0]        frgb;
    } command_t;

    logic                           aclk = 1'b0;
    logic                           aresetn;
    logic                           cfg_valid, cfg_ready;
    logic [fbrf_pkg::CFG_IDX_W-1:0] cfg_index;
    logic [7:0]                     cfg_data;
    logic                           s_valid, s_ready;
    logic [1:0]                     s_cmd;
    logic signed [15:0]   s_a_col, s_a_row, s_b_col, s_b_row, s_dest_col, s_dest_row;
    logic [7:0]                     s_band_width;
    logic                           s_fill_enable;
    logic [31:0]                    s_border_rgba;
    logic [23:0]                    s_fill_rgb;
    logic                           m_valid, m_ready;
    logic [31:0]                    m_pixel_value;
    logic                           m_status;

    int  mismatches;
    int  pending;
    int  cycles = 0;
    bit  quiet = 1'b0;
    bit  hold_go = 1'b0;
    int  cur_w = 128;
    int  cur_h = 128;

    always #4 aclk = ~aclk;

    framebuffer_rect_fill_and_blit_unit i_dut (.*);

    fbrf_checker i_checker (.*);

    // run limit
    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles > RUN_LIMIT) begin
            $display("simulation failed");
            $finish;
        end
    end

    // result side: random back-pressure plus one long hold-off
    always @(posedge aclk) begin
        int  hold_left;
        bit  hold_done;
        if (hold_go && !hold_done) begin
            hold_left = HOLD_LEN;
            hold_done = 1'b1;
        end
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else if (hold_left > 0) begin
            hold_left--;
            m_ready <= 1'b0;
        end else begin
            m_ready <= quiet ? 1'b1 : ($urandom_range(99) >= 23);
        end
    end

    function automatic command_t mk(fbrf_pkg::cmd_t c, int ac, int ar, int bc, int br,
                                    int dc, int dr, int bw, int fe);
        command_t t;
        t.cmd = c;
        t.ac = 16'(ac); t.ar = 16'(ar); t.bc = 16'(bc); t.br = 16'(br);
        t.dc = 16'(dc); t.dr = 16'(dr);
        t.bw = 8'(bw); t.fe = (fe != 0);
        t.brgba = $urandom;
        t.frgb = 24'($urandom);
        return t;
    endfunction

    // coordinate near the frame, now and then anywhere in the 16-bit range
    function automatic int near(int lim);
        if ($urandom_range(99) < 8) return int'($signed(16'($urandom)));
        return int'($urandom_range(lim + 8)) - 4;
    endfunction

    function automatic command_t random_command();
        command_t t;
        int span;
        span = ($urandom_range(15) == 0) ? 160 : 12;
        t = mk(fbrf_pkg::cmd_t'($urandom_range(3)), near(cur_w), near(cur_h), 0, 0,
               near(cur_w), near(cur_h), int'($urandom_range(6)),
               int'($urandom_range(1)));
        t.bc = 16'(int'(t.ac) + int'($urandom_range(span)) - span / 2);
        t.br = 16'(int'(t.ar) + int'($urandom_range(span)) - span / 2);
        if ($urandom_range(15) == 0) t.bc = 16'($urandom);
        if ($urandom_range(15) == 0) t.br = 16'($urandom);
        if ($urandom_range(9) == 0) t.bw = 8'($urandom);
        return t;
    endfunction

    // offer one command and wait for its transaction
    task automatic send(input command_t t);
        int gap;
        gap = 0;
        if (!quiet)
            while ($urandom_range(99) < 23) gap++;
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid       <= 1'b1;
        s_cmd         <= t.cmd;
        s_a_col       <= t.ac;
        s_a_row       <= t.ar;
        s_b_col       <= t.bc;
        s_b_row       <= t.br;
        s_dest_col    <= t.dc;
        s_dest_row    <= t.dr;
        s_band_width  <= t.bw;
        s_fill_enable <= t.fe;
        s_border_rgba <= t.brgba;
        s_fill_rgb    <= t.frgb;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
    endtask

    // wait until every result has come back
    task automatic drain();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (pending != 0) @(posedge aclk);
        repeat (8) @(posedge aclk);
    endtask

    task automatic write_reg(input logic [fbrf_pkg::CFG_IDX_W-1:0] idx,
                             input logic [7:0] val);
        drain();
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        cfg_valid <= 1'b0;
    endtask

    task automatic set_frame(input int cols, input int rows);
        write_reg(fbrf_pkg::CFG_FRAME_COLS, 8'(cols));
        write_reg(fbrf_pkg::CFG_FRAME_ROWS, 8'(rows));
        cur_w = (cols > 128) ? 128 : cols;
        cur_h = (rows > 128) ? 128 : rows;
    endtask

    task automatic random_phase(input int n);
        repeat (n) send(random_command());
    endtask

    initial begin
        aresetn       <= 1'b0;
        cfg_valid     <= 1'b0;
        cfg_index     <= '0;
        cfg_data      <= '0;
        s_valid       <= 1'b0;
        s_cmd         <= fbrf_pkg::CMD_WRITE;
        s_a_col       <= '0;
        s_a_row       <= '0;
        s_b_col       <= '0;
        s_b_row       <= '0;
        s_dest_col    <= '0;
        s_dest_row    <= '0;
        s_band_width  <= '0;
        s_fill_enable <= 1'b0;
        s_border_rgba <= '0;
        s_fill_rgb    <= '0;
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // a filled full-frame rectangle writes every entry before any read
        quiet = 1'b1;
        send(mk(fbrf_pkg::CMD_RECT, 0, 0, 127, 127, 0, 0, 0, 1));
        quiet = 1'b0;

        // directed commands
        send(mk(fbrf_pkg::CMD_WRITE, 0, 0, 0, 0, 0, 0, 0, 0));
        send(mk(fbrf_pkg::CMD_WRITE, 127, 127, 0, 0, 0, 0, 0, 0));
        send(mk(fbrf_pkg::CMD_WRITE, -1, 5, 0, 0, 0, 0, 0, 0));
        send(mk(fbrf_pkg::CMD_WRITE, 32767, -32768, 0, 0, 0, 0, 0, 0));
        send(mk(fbrf_pkg::CMD_READ, 0, 0, 0, 0, 0, 0, 0, 0));
        send(mk(fbrf_pkg::CMD_READ, 127, 127, 0, 0, 0, 0, 0, 0));
        send(mk(fbrf_pkg::CMD_READ, 128, 0, 0, 0, 0, 0, 0, 0));
        send(mk(fbrf_pkg::CMD_READ, -32768, 32767, 0, 0, 0, 0, 0, 0));
        send(mk(fbrf_pkg::CMD_RECT, 2, 3, 10, 8, 0, 0, 2, 1));
        send(mk(fbrf_pkg::CMD_RECT, 20, 15, 12, 9, 0, 0, 0, 0));
        send(mk(fbrf_pkg::CMD_RECT, 60, 60, 61, 61, 0, 0, 255, 1));
        send(mk(fbrf_pkg::CMD_RECT, -32768, -32768, 32767, 32767, 0, 0, 0, 0));
        send(mk(fbrf_pkg::CMD_READ, 5, 4, 0, 0, 0, 0, 0, 0));
        send(mk(fbrf_pkg::CMD_COPY, 5, 5, 5, 9, 0, 0, 0, 0));
        send(mk(fbrf_pkg::CMD_COPY, -1, 0, 4, 4, 0, 0, 0, 0));
        send(mk(fbrf_pkg::CMD_COPY, 120, 0, 129, 3, 0, 0, 0, 0));
        send(mk(fbrf_pkg::CMD_COPY, 0, 0, 4, 4, 128, 0, 0, 0));
        send(mk(fbrf_pkg::CMD_COPY, 0, 0, 4, 4, 3, -1, 0, 0));
        send(mk(fbrf_pkg::CMD_COPY, 0, 0, 8, 8, 124, 125, 0, 0));
        send(mk(fbrf_pkg::CMD_COPY, 0, 0, 10, 10, 3, 2, 0, 0));
        send(mk(fbrf_pkg::CMD_COPY, 10, 10, 0, 0, 50, 50, 0, 0));
        send(mk(fbrf_pkg::CMD_READ, 5, 4, 0, 0, 0, 0, 0, 0));
        send(mk(fbrf_pkg::CMD_READ, 127, 126, 0, 0, 0, 0, 0, 0));

        // long receiver hold-off while commands keep coming
        hold_go = 1'b1;
        random_phase(15);

        // sender pause until the engine has caught up
        drain();
        quiet = 1'b1;
        random_phase(12);
        quiet = 1'b0;

        set_frame(1, 1);
        random_phase(8);
        set_frame(0, 0);
        random_phase(6);
        write_reg(CFG_UNMAPPED, 8'd3);
        set_frame(255, 200);
        random_phase(10);
        set_frame(16, 12);
        random_phase(12);
        set_frame(40, 128);
        random_phase(12);

        drain();
        repeat (50) @(posedge aclk);
        if (mismatches == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule
